FILE: hw/rtl/vrc_pkg.sv
// Shared constants, codes, types and saturating adders of the route cost evaluator.
package vrc_pkg;

  localparam int unsigned MAX_NODES    = 256;
  localparam int unsigned MAX_ROUTES   = 256;
  localparam int unsigned ROUTE_CAP    = (MAX_ROUTES < 511) ? MAX_ROUTES : 511;
  localparam int unsigned NODE_AW      = $clog2(MAX_NODES);
  localparam int unsigned TRAVEL_AW    = 2 * NODE_AW;
  localparam int unsigned TRAVEL_DEPTH = 2 ** TRAVEL_AW;
  localparam int unsigned RES_DEPTH    = 16;
  localparam int unsigned RES_AW       = $clog2(RES_DEPTH);

  typedef enum logic [1:0] {
    OP_LOAD_COST   = 2'd0,
    OP_LOAD_CLIENT = 2'd1,
    OP_VISIT       = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_CAPACITY    = 2'd0,
    CFG_DURATION    = 2'd1,
    CFG_CAP_PENALTY = 2'd2,
    CFG_DUR_PENALTY = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        feasible;
    logic [47:0] penalized_cost;
    logic [31:0] duration_excess;
    logic [31:0] capacity_excess;
    logic [8:0]  route_count;
    logic [31:0] total_distance;
  } res_t;

  function automatic logic [23:0] sat_add24(input logic [23:0] a, input logic [16:0] b);
    logic [24:0] s;
    s = {1'b0, a} + 25'(b);
    return s[24] ? 24'hFF_FFFF : s[23:0];
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [24:0] b);
    logic [32:0] s;
    s = {1'b0, a} + 33'(b);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

FILE: hw/rtl/vrc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module vrc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hw/rtl/vrp_route_cost_evaluator.sv
// Top level of the route cost evaluator: table loads, route scoring and result queue.
//
//   channel  direction  tdata                                     tuser / tlast
//   in_      slave      node, column, amount, service_time        op, route_end / solution_end
//   out_     master     distance, routes, excesses, penalty cost  feasible / -
//   cfg_     write      register index 0..3, 24-bit value         -
//
// One beat is taken every cycle while in_tready is high; a solution result passes the
// registered table reads and the scoring, multiply and add stages before it is queued.
// Results wait in a sixteen-deep queue; in_tready falls only when sixteen results are
// accepted but not yet delivered. Reset (synchronous, rst_n low) clears the route state,
// accumulators, queue, limits (to 0) and penalties (to 256); the tables keep their data.
module vrp_route_cost_evaluator
  import vrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // node, column, amount, service_time
  input  logic [2:0]   in_tuser,   // op, route_end
  input  logic         in_tlast,   // solution_end
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // total_distance, route_count, capacity_excess,
                                   // duration_excess, penalized_cost, zero fill
  output logic [0:0]   out_tuser   // feasible
);

  // Configuration
  logic [23:0] capacity_r, duration_r, cap_pen_r, dur_pen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
      duration_r <= '0;
      cap_pen_r  <= 24'd256;
      dur_pen_r  <= 24'd256;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CAPACITY:    capacity_r <= cfg_wdata;
        CFG_DURATION:    duration_r <= cfg_wdata;
        CFG_CAP_PENALTY: cap_pen_r  <= cfg_wdata;
        CFG_DUR_PENALTY: dur_pen_r  <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  // Input beat decode
  logic        in_fire;
  op_t         in_op;
  logic [7:0]  in_node, in_column;
  logic [15:0] in_amount, in_service;
  logic        in_close, in_send;
  logic        node_ok, column_ok, prev_ok;
  logic        is_visit;
  logic [7:0]  prev_stop_r, prev_stop_nxt;

  assign in_fire    = in_tvalid && in_tready;
  assign in_op      = op_t'(in_tuser[1:0]);
  assign in_node    = in_tdata[7:0];
  assign in_column  = in_tdata[15:8];
  assign in_amount  = in_tdata[31:16];
  assign in_service = in_tdata[47:32];
  assign in_send    = in_tlast;
  assign in_close   = in_tuser[2] || in_tlast;
  assign node_ok    = 32'(in_node) < MAX_NODES;
  assign column_ok  = 32'(in_column) < MAX_NODES;
  assign prev_ok    = 32'(prev_stop_r) < MAX_NODES;
  assign is_visit   = in_fire && (in_op == OP_VISIT);

  // A closed route starts again from the depot.
  assign prev_stop_nxt = is_visit ? (in_close ? 8'd0 : in_node) : prev_stop_r;

  // Tables. The leg back to the depot lives in a copy of column zero so that a route
  // end reads its inbound and return legs in the same cycle.
  logic                 travel_we, return_we, client_we;
  logic [TRAVEL_AW-1:0] travel_waddr, travel_raddr;
  logic [15:0]          travel_rdata, return_rdata;
  logic [31:0]          client_rdata;

  assign travel_we    = in_fire && (in_op == OP_LOAD_COST) && node_ok && column_ok;
  assign return_we    = travel_we && (in_column == 8'd0);
  assign client_we    = in_fire && (in_op == OP_LOAD_CLIENT) && node_ok;
  assign travel_waddr = {NODE_AW'(in_node), NODE_AW'(in_column)};
  assign travel_raddr = {NODE_AW'(prev_stop_r), NODE_AW'(in_node)};

  vrc_ram #(.WIDTH(16), .DEPTH(TRAVEL_DEPTH)) u_travel_ram (
    .clk     (clk),
    .wr_en   (travel_we),
    .wr_addr (travel_waddr),
    .wr_data (in_amount),
    .rd_addr (travel_raddr),
    .rd_data (travel_rdata)
  );

  vrc_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_return_ram (
    .clk     (clk),
    .wr_en   (return_we),
    .wr_addr (NODE_AW'(in_node)),
    .wr_data (in_amount),
    .rd_addr (NODE_AW'(in_node)),
    .rd_data (return_rdata)
  );

  vrc_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_client_ram (
    .clk     (clk),
    .wr_en   (client_we),
    .wr_addr (NODE_AW'(in_node)),
    .wr_data ({in_service, in_amount}),
    .rd_addr (NODE_AW'(in_node)),
    .rd_data (client_rdata)
  );

  // Stage 1: table data arrives; form the leg sum and mask out-of-range reads.
  logic        rd_valid_r, rd_close_r, rd_send_r, rd_leg_ok_r, rd_node_ok_r;
  logic [15:0] leg_cost, ret_cost, dem_val, svc_val;
  logic [16:0] leg_sum;

  assign leg_cost = rd_leg_ok_r ? travel_rdata : 16'd0;
  assign ret_cost = (rd_close_r && rd_node_ok_r) ? return_rdata : 16'd0;
  assign dem_val  = rd_node_ok_r ? client_rdata[15:0] : 16'd0;
  assign svc_val  = rd_node_ok_r ? client_rdata[31:16] : 16'd0;
  assign leg_sum  = 17'(leg_cost) + 17'(ret_cost);

  // Stage 2: route accumulators.
  logic        rt_valid_r, rt_close_r, rt_send_r;
  logic [16:0] rt_leg_r;
  logic [15:0] rt_dem_r, rt_svc_r;
  logic [23:0] route_dist_r, route_load_r, route_svc_r;
  logic [23:0] route_dist_nxt, route_load_nxt, route_svc_nxt;
  logic [23:0] dist_upd, load_upd, svc_upd;

  // Saturating the two legs one after the other equals saturating their sum.
  assign dist_upd = sat_add24(route_dist_r, rt_leg_r);
  assign load_upd = sat_add24(route_load_r, 17'(rt_dem_r));
  assign svc_upd  = sat_add24(route_svc_r, 17'(rt_svc_r));

  always_comb begin
    route_dist_nxt = route_dist_r;
    route_load_nxt = route_load_r;
    route_svc_nxt  = route_svc_r;
    if (rt_valid_r) begin
      if (rt_close_r) begin
        route_dist_nxt = '0;
        route_load_nxt = '0;
        route_svc_nxt  = '0;
      end else begin
        route_dist_nxt = dist_upd;
        route_load_nxt = load_upd;
        route_svc_nxt  = svc_upd;
      end
    end
  end

  // Stage 3: closed route; duration and load excess.
  logic        cl_valid_r, cl_send_r;
  logic [23:0] cl_dist_r, cl_load_r, cl_svc_r;
  logic [24:0] cl_dur, load_diff;
  logic [23:0] load_exc;

  assign cl_dur    = 25'(cl_dist_r) + 25'(cl_svc_r);
  assign load_diff = {1'b0, cl_load_r} - {1'b0, capacity_r};
  assign load_exc  = load_diff[24] ? 24'd0 : load_diff[23:0];

  // Stage 4: duration excess.
  logic        ex_valid_r, ex_send_r;
  logic [23:0] ex_dist_r, ex_lexc_r;
  logic [24:0] ex_dur_r;
  logic [25:0] dur_diff;
  logic [24:0] dur_exc;

  assign dur_diff = {1'b0, ex_dur_r} - 26'(duration_r);
  assign dur_exc  = dur_diff[25] ? 25'd0 : dur_diff[24:0];

  // Stage 5: solution accumulators.
  logic        ac_valid_r, ac_send_r;
  logic [23:0] ac_dist_r, ac_lexc_r;
  logic [24:0] ac_texc_r;
  logic [31:0] dist_sum_r, lexc_sum_r, texc_sum_r;
  logic [8:0]  routes_r;
  logic [31:0] dist_sum_upd, lexc_sum_upd, texc_sum_upd;
  logic [8:0]  routes_upd;
  logic [31:0] dist_sum_nxt, lexc_sum_nxt, texc_sum_nxt;
  logic [8:0]  routes_nxt;
  logic        take_route, sol_done;

  assign take_route   = ac_valid_r && (routes_r < 9'(ROUTE_CAP));
  assign dist_sum_upd = take_route ? sat_add32(dist_sum_r, 25'(ac_dist_r)) : dist_sum_r;
  assign lexc_sum_upd = take_route ? sat_add32(lexc_sum_r, 25'(ac_lexc_r)) : lexc_sum_r;
  assign texc_sum_upd = take_route ? sat_add32(texc_sum_r, ac_texc_r) : texc_sum_r;
  assign routes_upd   = take_route ? routes_r + 9'd1 : routes_r;
  assign sol_done     = ac_valid_r && ac_send_r;

  always_comb begin
    if (sol_done) begin
      dist_sum_nxt = '0;
      lexc_sum_nxt = '0;
      texc_sum_nxt = '0;
      routes_nxt   = '0;
    end else begin
      dist_sum_nxt = dist_sum_upd;
      lexc_sum_nxt = lexc_sum_upd;
      texc_sum_nxt = texc_sum_upd;
      routes_nxt   = routes_upd;
    end
  end

  // Stages 6 to 8: totals, penalty products, product sum.
  logic        tot_valid_r, mu_valid_r, sm_valid_r;
  logic [31:0] tot_dist_r, tot_lexc_r, tot_texc_r;
  logic [8:0]  tot_routes_r;
  logic [31:0] mu_dist_r, mu_lexc_r, mu_texc_r;
  logic [8:0]  mu_routes_r;
  logic [55:0] mu_pcap_r, mu_pdur_r;
  logic [31:0] sm_dist_r, sm_lexc_r, sm_texc_r;
  logic [8:0]  sm_routes_r;
  logic [56:0] sm_psum_r;
  logic [57:0] cost_q8;
  logic [49:0] cost_int;
  res_t        res_in;

  assign cost_q8  = 58'(sm_psum_r) + 58'({sm_dist_r, 8'd0});
  assign cost_int = cost_q8[57:8];

  always_comb begin
    res_in.total_distance  = sm_dist_r;
    res_in.route_count     = sm_routes_r;
    res_in.capacity_excess = sm_lexc_r;
    res_in.duration_excess = sm_texc_r;
    res_in.penalized_cost  = (|cost_int[49:48]) ? 48'hFFFF_FFFF_FFFF : cost_int[47:0];
    res_in.feasible        = (sm_lexc_r == 32'd0) && (sm_texc_r == 32'd0);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_stop_r  <= '0;
      rd_valid_r   <= 1'b0;
      rt_valid_r   <= 1'b0;
      cl_valid_r   <= 1'b0;
      ex_valid_r   <= 1'b0;
      ac_valid_r   <= 1'b0;
      tot_valid_r  <= 1'b0;
      mu_valid_r   <= 1'b0;
      sm_valid_r   <= 1'b0;
      route_dist_r <= '0;
      route_load_r <= '0;
      route_svc_r  <= '0;
      dist_sum_r   <= '0;
      lexc_sum_r   <= '0;
      texc_sum_r   <= '0;
      routes_r     <= '0;
    end else begin
      prev_stop_r  <= prev_stop_nxt;
      rd_valid_r   <= is_visit;
      rt_valid_r   <= rd_valid_r;
      cl_valid_r   <= rt_valid_r && rt_close_r;
      ex_valid_r   <= cl_valid_r;
      ac_valid_r   <= ex_valid_r;
      tot_valid_r  <= sol_done;
      mu_valid_r   <= tot_valid_r;
      sm_valid_r   <= mu_valid_r;
      route_dist_r <= route_dist_nxt;
      route_load_r <= route_load_nxt;
      route_svc_r  <= route_svc_nxt;
      dist_sum_r   <= dist_sum_nxt;
      lexc_sum_r   <= lexc_sum_nxt;
      texc_sum_r   <= texc_sum_nxt;
      routes_r     <= routes_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rd_close_r   <= in_close;
    rd_send_r    <= in_send;
    rd_leg_ok_r  <= prev_ok && node_ok;
    rd_node_ok_r <= node_ok;

    rt_close_r   <= rd_close_r;
    rt_send_r    <= rd_send_r;
    rt_leg_r     <= leg_sum;
    rt_dem_r     <= dem_val;
    rt_svc_r     <= svc_val;

    cl_send_r    <= rt_send_r;
    cl_dist_r    <= dist_upd;
    cl_load_r    <= load_upd;
    cl_svc_r     <= svc_upd;

    ex_send_r    <= cl_send_r;
    ex_dist_r    <= cl_dist_r;
    ex_lexc_r    <= load_exc;
    ex_dur_r     <= cl_dur;

    ac_send_r    <= ex_send_r;
    ac_dist_r    <= ex_dist_r;
    ac_lexc_r    <= ex_lexc_r;
    ac_texc_r    <= dur_exc;

    tot_dist_r   <= dist_sum_upd;
    tot_lexc_r   <= lexc_sum_upd;
    tot_texc_r   <= texc_sum_upd;
    tot_routes_r <= routes_upd;

    mu_dist_r    <= tot_dist_r;
    mu_lexc_r    <= tot_lexc_r;
    mu_texc_r    <= tot_texc_r;
    mu_routes_r  <= tot_routes_r;
    mu_pcap_r    <= tot_lexc_r * cap_pen_r;
    mu_pdur_r    <= tot_texc_r * dur_pen_r;

    sm_dist_r    <= mu_dist_r;
    sm_lexc_r    <= mu_lexc_r;
    sm_texc_r    <= mu_texc_r;
    sm_routes_r  <= mu_routes_r;
    sm_psum_r    <= 57'(mu_pcap_r) + 57'(mu_pdur_r);
  end

  // Result queue. Every solution end accepted holds a credit until its result beat
  // leaves, so the queue cannot overflow while the pipeline runs freely.
  res_t              res_mem [RES_DEPTH];
  logic [RES_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [RES_AW:0]   fill_r, pend_r;
  logic              out_fire, sol_accept;
  res_t              res_out;

  assign out_fire   = out_tvalid && out_tready;
  assign sol_accept = is_visit && in_send;
  assign out_tvalid = fill_r != '0;
  assign in_tready  = pend_r != (RES_AW + 1)'(RES_DEPTH);
  assign res_out    = res_mem[rd_ptr_r];
  assign out_tdata  = {7'd0, res_out.penalized_cost, res_out.duration_excess,
                       res_out.capacity_excess, res_out.route_count,
                       res_out.total_distance};
  assign out_tuser  = res_out.feasible;

  always_ff @(posedge clk) begin
    if (sm_valid_r) begin
      res_mem[wr_ptr_r] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      pend_r   <= '0;
    end else begin
      if (sm_valid_r) begin
        wr_ptr_r <= wr_ptr_r + RES_AW'(1);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + RES_AW'(1);
      end
      fill_r <= fill_r + (RES_AW + 1)'(sm_valid_r) - (RES_AW + 1)'(out_fire);
      pend_r <= pend_r + (RES_AW + 1)'(sol_accept) - (RES_AW + 1)'(out_fire);
    end
  end

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench of the route cost evaluator: directed table, route-shaped random traffic.
`timescale 1ns / 1ps

module tb
  import vrc_pkg::*;
();

  localparam int ITEM_TARGET  = 1700;
  localparam int PIPE_LATENCY = 9;
  localparam int DRAIN_PAUSE  = PIPE_LATENCY + 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int PLAN_ROWS    = 21;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  node;
    logic [7:0]  column;
    logic [15:0] amount;
    logic [15:0] svc;
    logic        rend;
    logic        send;
  } beat_t;

  typedef struct packed {
    beat_t b;
    logic  fixed;
    res_t  want;
  } plan_row_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_wr_en;
  logic [1:0]   cfg_index;
  logic [23:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [47:0]  in_tdata;   // node, column, amount, service_time
  logic [2:0]   in_tuser;   // op, route_end
  logic         in_tlast;   // solution_end
  logic         out_tvalid;
  logic         out_tready;
  logic [159:0] out_tdata;  // total_distance, route_count, capacity_excess,
                            // duration_excess, penalized_cost, zero fill
  logic [0:0]   out_tuser;  // feasible

  vrp_route_cost_evaluator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Predictor state: tables with written flags, the open route and the solution totals.
  logic [15:0] leg_cost     [0:65535];
  bit          leg_known    [0:65535];
  logic [15:0] demand_of    [0:255];
  logic [15:0] service_of   [0:255];
  bit          client_known [0:255];
  logic [7:0]  last_stop;
  logic [23:0] leg_sum, load_sum, svc_sum;
  logic [31:0] dist_total, over_load, over_time;
  logic [8:0]  n_routes;
  logic [23:0] cap_lim, dur_lim, cap_pen, dur_pen;

  res_t sol_q[$];
  int   mismatch_count = 0;
  int   beats_sent = 0;
  int   dry_cycles = 0;
  bit   hold_req = 1'b0;
  bit   send_idle = 1'b1;
  bit   sink_idle = 1'b1;

  // Result fields in package order: feasible, penalized_cost, duration_excess,
  // capacity_excess, route_count, total_distance. Rows typed in are at reset settings.
  plan_row_t plan [PLAN_ROWS] = '{
    '{'{OP_LOAD_COST,   8'd0,   8'd5,   16'd10,    16'd0,     1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_LOAD_COST,   8'd5,   8'd0,   16'd20,    16'd0,     1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_LOAD_CLIENT, 8'd5,   8'd0,   16'd3,     16'd4,     1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_VISIT,       8'd5,   8'd0,   16'd0,     16'd0,     1'b1, 1'b1}, 1'b1,
      '{1'b0, 48'd67, 32'd34, 32'd3, 9'd1, 32'd30}},
    '{'{OP_RESERVED,    8'hFF,  8'hFF,  16'hFFFF,  16'hFFFF,  1'b1, 1'b1}, 1'b0, '0},
    '{'{OP_LOAD_COST,   8'd0,   8'd0,   16'd0,     16'd0,     1'b1, 1'b1}, 1'b0, '0},
    '{'{OP_LOAD_CLIENT, 8'd0,   8'd0,   16'd0,     16'd0,     1'b1, 1'b1}, 1'b0, '0},
    '{'{OP_VISIT,       8'd0,   8'd0,   16'd0,     16'd0,     1'b0, 1'b1}, 1'b1,
      '{1'b1, 48'd0, 32'd0, 32'd0, 9'd1, 32'd0}},
    '{'{OP_LOAD_COST,   8'd0,   8'd255, 16'hFFFF,  16'd0,     1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_LOAD_COST,   8'd255, 8'd255, 16'hFFFF,  16'd0,     1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_LOAD_COST,   8'd255, 8'd0,   16'hFFFF,  16'd0,     1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_LOAD_CLIENT, 8'd255, 8'd0,   16'hFFFF,  16'hFFFF,  1'b1, 1'b0}, 1'b0, '0},
    '{'{OP_VISIT,       8'd255, 8'd0,   16'd0,     16'd0,     1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_VISIT,       8'd255, 8'd0,   16'd0,     16'd0,     1'b1, 1'b1}, 1'b1,
      '{1'b0, 48'd655350, 32'd327675, 32'd131070, 9'd1, 32'd196605}},
    '{'{OP_VISIT,       8'd5,   8'd0,   16'd0,     16'd0,     1'b1, 1'b0}, 1'b0, '0},
    '{'{OP_VISIT,       8'd255, 8'd0,   16'd0,     16'd0,     1'b1, 1'b1}, 1'b0, '0},
    '{'{OP_LOAD_COST,   8'd5,   8'd255, 16'd7,     16'd0,     1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_LOAD_COST,   8'd255, 8'd5,   16'd9,     16'd0,     1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_VISIT,       8'd5,   8'd0,   16'd0,     16'd0,     1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_VISIT,       8'd255, 8'd0,   16'd0,     16'd0,     1'b0, 1'b0}, 1'b0, '0},
    '{'{OP_VISIT,       8'd5,   8'd0,   16'd0,     16'd0,     1'b1, 1'b1}, 1'b0, '0}
  };

  initial begin : clock_gen
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [23:0] clip24(input logic [63:0] v);
    return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
  endfunction

  function automatic logic [31:0] clip32(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  task automatic clear_route();
    last_stop = 8'd0;
    leg_sum   = '0;
    load_sum  = '0;
    svc_sum   = '0;
  endtask

  // Charges the return leg and, while the route limit allows, scores the route.
  task automatic close_route();
    logic [63:0] span;
    leg_sum = clip24(64'(leg_sum) + 64'(leg_cost[{last_stop, 8'd0}]));
    if (n_routes < ROUTE_CAP) begin
      span       = 64'(leg_sum) + 64'(svc_sum);
      dist_total = clip32(64'(dist_total) + 64'(leg_sum));
      n_routes   = n_routes + 9'd1;
      if (load_sum > cap_lim)
        over_load = clip32(64'(over_load) + 64'(load_sum - cap_lim));
      if (span > 64'(dur_lim))
        over_time = clip32(64'(over_time) + span - 64'(dur_lim));
    end
    clear_route();
  endtask

  task automatic score_beat(input beat_t b, output logic got, output res_t r);
    logic [63:0] q8;
    got = 1'b0;
    r   = '0;
    case (b.op)
      OP_LOAD_COST: begin
        leg_cost[{b.node, b.column}]  = b.amount;
        leg_known[{b.node, b.column}] = 1'b1;
      end
      OP_LOAD_CLIENT: begin
        demand_of[b.node]    = b.amount;
        service_of[b.node]   = b.svc;
        client_known[b.node] = 1'b1;
      end
      OP_VISIT: begin
        leg_sum   = clip24(64'(leg_sum) + 64'(leg_cost[{last_stop, b.node}]));
        load_sum  = clip24(64'(load_sum) + 64'(demand_of[b.node]));
        svc_sum   = clip24(64'(svc_sum) + 64'(service_of[b.node]));
        last_stop = b.node;
        if (b.rend || b.send) close_route();
        if (b.send) begin
          q8 = (64'(dist_total) << 8) + 64'(over_load) * 64'(cap_pen)
             + 64'(over_time) * 64'(dur_pen);
          q8 = q8 >> 8;
          r.total_distance  = dist_total;
          r.route_count     = n_routes;
          r.capacity_excess = over_load;
          r.duration_excess = over_time;
          r.penalized_cost  = (q8 > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : q8[47:0];
          r.feasible        = (over_load == 0) && (over_time == 0);
          got               = 1'b1;
          clear_route();
          dist_total = '0;
          n_routes   = '0;
          over_load  = '0;
          over_time  = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] exp);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, exp);
    mismatch_count++;
  endtask

  // Offers one beat from a falling edge, waits for the handshake and returns at the
  // next falling edge.
  task automatic send_beat(input beat_t b, input logic fixed, input res_t want);
    logic got;
    res_t r;
    if (send_idle && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b.svc, b.amount, b.column, b.node};
    in_tuser  <= {b.rend, b.op};
    in_tlast  <= b.send;
    do @(posedge clk); while (!in_tready);
    score_beat(b, got, r);
    if (got) sol_q.insert(sol_q.size(), fixed ? want : r);
    if (b.op != OP_RESERVED) beats_sent++;
    @(negedge clk);
  endtask

  task automatic write_settings(input logic [23:0] cap, input logic [23:0] dur,
                                input logic [23:0] cpen, input logic [23:0] dpen);
    cfg_reg_t    idx [4];
    logic [23:0] val [4];
    idx = '{CFG_CAPACITY, CFG_DURATION, CFG_CAP_PENALTY, CFG_DUR_PENALTY};
    val = '{cap, dur, cpen, dpen};
    for (int k = 0; k < 4; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    cap_lim = cap;
    dur_lim = dur;
    cap_pen = cpen;
    dur_pen = dpen;
  endtask

  // Lowers the input, waits for every pending solution, then lets the pipeline settle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sol_q.size() != 0) @(negedge clk);
    repeat (DRAIN_PAUSE) @(negedge clk);
  endtask

  function automatic logic [15:0] any_amount();
    return ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 999));
  endfunction

  function automatic logic [7:0] pick_node();
    return ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 10));
  endfunction

  task automatic load_leg(input logic [7:0] src, input logic [7:0] dst,
                          input logic [15:0] amt);
    beat_t b;
    b        = 52'({$urandom, $urandom});
    b.op     = OP_LOAD_COST;
    b.node   = src;
    b.column = dst;
    b.amount = amt;
    send_beat(b, 1'b0, '0);
  endtask

  task automatic load_client(input logic [7:0] n, input logic [15:0] dem,
                             input logic [15:0] svc);
    beat_t b;
    b        = 52'({$urandom, $urandom});
    b.op     = OP_LOAD_CLIENT;
    b.node   = n;
    b.amount = dem;
    b.svc    = svc;
    send_beat(b, 1'b0, '0);
  endtask

  task automatic need_leg(input logic [7:0] src, input logic [7:0] dst);
    if (!leg_known[{src, dst}]) load_leg(src, dst, any_amount());
  endtask

  // A visit never reads a table entry that has not been loaded: missing legs and
  // client data are loaded just ahead of it.
  task automatic visit(input logic [7:0] n, input logic rend, input logic send);
    beat_t b;
    need_leg(last_stop, n);
    if (!client_known[n]) load_client(n, any_amount(), any_amount());
    if (rend || send) need_leg(n, 8'd0);
    b      = 52'({$urandom, $urandom});
    b.op   = OP_VISIT;
    b.node = n;
    b.rend = rend;
    b.send = send;
    send_beat(b, 1'b0, '0);
  endtask

  task automatic noise_beat();
    beat_t b;
    b = 52'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: b.op = OP_RESERVED;
      1: b.op = OP_LOAD_COST;
      2: b.op = OP_LOAD_CLIENT;
      default: begin
        // A stray visit, possibly closing a route without ending the solution.
        visit(pick_node(), 1'($urandom), 1'b0);
        return;
      end
    endcase
    send_beat(b, 1'b0, '0);
  endtask

  task automatic random_solution();
    int   routes;
    int   len;
    logic fin;
    routes = $urandom_range(1, 4);
    for (int r = 0; r < routes; r++) begin
      len = $urandom_range(1, 5);
      for (int k = 0; k < len; k++) begin
        fin = (r == routes - 1) && (k == len - 1);
        if ($urandom_range(0, 11) == 0) noise_beat();
        // Now and then the solution end arrives without its route end.
        visit(pick_node(), (k == len - 1) && !(fin && $urandom_range(0, 7) == 0), fin);
      end
    end
  endtask

  task automatic random_chunk(input int target);
    int start;
    start = beats_sent;
    while (beats_sent - start < target) begin
      if ($urandom_range(0, 5) == 0) noise_beat();
      else random_solution();
    end
    random_solution();
  endtask

  initial begin : stimulus
    int phase;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    in_tlast  = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_CAPACITY;
    cfg_wdata = '0;
    clear_route();
    dist_total = '0;
    n_routes   = '0;
    over_load  = '0;
    over_time  = '0;
    cap_lim    = 24'd0;
    dur_lim    = 24'd0;
    cap_pen    = 24'd256;
    dur_pen    = 24'd256;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) send_beat(plan[i].b, plan[i].fixed, plan[i].want);
    wait_drained();

    phase = 0;
    while (beats_sent < ITEM_TARGET) begin
      case (phase % 4)
        0: write_settings(24'($urandom_range(0, 3000)), 24'($urandom_range(0, 12000)),
                          24'($urandom_range(0, 1023)), 24'($urandom_range(0, 1023)));
        1: write_settings(24'hFF_FFFF, 24'hFF_FFFF, 24'd0, 24'd0);
        2: write_settings(24'd0, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF);
        default: write_settings(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
      endcase
      send_idle = (phase % 3 != 2);
      sink_idle = (phase % 3 != 2);
      if (beats_sent > ITEM_TARGET - 300) begin
        send_idle = 1'b0;
        sink_idle = 1'b0;
      end
      case (phase)
        1: begin
          // The sink holds off while short solutions keep coming, so the result
          // queue fills and the input has to stall.
          send_idle = 1'b0;
          hold_req  = 1'b1;
          repeat (60) visit(pick_node(), 1'b1, 1'b1);
        end
        3: begin
          // One route long enough to saturate distance, load and service sums.
          load_leg(8'd0, 8'd200, 16'hFFFF);
          load_leg(8'd200, 8'd200, 16'hFFFF);
          load_leg(8'd200, 8'd0, 16'hFFFF);
          load_client(8'd200, 16'hFFFF, 16'hFFFF);
          repeat (259) visit(8'd200, 1'b0, 1'b0);
          visit(8'd200, 1'b1, 1'b1);
        end
        6: begin
          // More routes than the block scores in one solution.
          for (int k = 0; k < 270; k++) visit(8'd3, 1'b1, k == 269);
        end
        default: ;
      endcase
      random_chunk(150);
      wait_drained();
      phase++;
    end

    if (mismatch_count == 0) begin
      $display("vrp_route_cost_evaluator verification clean");
    end else begin
      $display("vrp_route_cost_evaluator verification failed");
    end
    $finish;
  end

  initial begin : sink
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 17);
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (sol_q.size() == 0) begin
        flag_mismatch("unexpected result", 64'(out_tdata[31:0]), 64'd0);
      end else begin
        want = sol_q.pop_front();
        if (out_tdata[31:0] !== want.total_distance)
          flag_mismatch("total_distance", 64'(out_tdata[31:0]),
                        64'(want.total_distance));
        if (out_tdata[40:32] !== want.route_count)
          flag_mismatch("route_count", 64'(out_tdata[40:32]), 64'(want.route_count));
        if (out_tdata[72:41] !== want.capacity_excess)
          flag_mismatch("capacity_excess", 64'(out_tdata[72:41]),
                        64'(want.capacity_excess));
        if (out_tdata[104:73] !== want.duration_excess)
          flag_mismatch("duration_excess", 64'(out_tdata[104:73]),
                        64'(want.duration_excess));
        if (out_tdata[152:105] !== want.penalized_cost)
          flag_mismatch("penalized_cost", 64'(out_tdata[152:105]),
                        64'(want.penalized_cost));
        if (out_tdata[159:153] !== 7'd0)
          flag_mismatch("zero fill", 64'(out_tdata[159:153]), 64'd0);
        if (out_tuser[0] !== want.feasible)
          flag_mismatch("feasible", 64'(out_tuser[0]), 64'(want.feasible));
      end
    end
  end

  // Ends the run when neither channel has moved a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) dry_cycles = 0;
    else dry_cycles++;
    if (dry_cycles >= STALL_LIMIT) begin
      $display("vrp_route_cost_evaluator verification failed");
      $finish;
    end
  end

endmodule
